>>> rtl/core/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Holds the request and result word structs, operation and status codes,
// and the interface types of the shared arithmetic unit. No dependencies.
package ffba_pkg;

    localparam int WORD_W = 25;

    localparam int ALIGN_BYTES = 32;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_REINIT = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic [23:0] POOL_LIMIT = 24'h800000;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] req_size;
        logic [22:0] free_addr;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [22:0] payload_addr;
        logic [23:0] free_total;
        logic [6:0]  free_blocks;
        logic [23:0] used_total;
        logic [6:0]  used_blocks;
    } out_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] dif;
        logic              eq;
        logic              gt;
    } alu_out_t;

endpackage

>>> rtl/core/ffba_alu.sv
// Shared add, subtract and compare unit of the allocator sequencer.
// Depends on ffba_pkg for its operand and result structs.
module ffba_alu (
    input  ffba_pkg::alu_in_t  alu_in,
    output ffba_pkg::alu_out_t alu_out
);

    always_comb begin
        alu_out.sum = alu_in.a + alu_in.b;
        alu_out.dif = alu_in.a - alu_in.b;
        alu_out.eq  = (alu_in.a == alu_in.b);
        alu_out.gt  = (alu_in.a > alu_in.b);
    end

endmodule

>>> rtl/core/first_fit_block_allocator_unit.sv
// First-fit block allocator: top level with descriptor memories and sequencer.
// Depends on ffba_pkg and ffba_alu.
//
// The block accepts one request word at a time, in the idle state only.
// An allocate first rounds the size up to the alignment on the shared unit,
// then scans the free list, each entry with one read of the free-list
// memory, one read of the size memory and one compare; it moves up each
// later entry when the taken entry is removed, searches the descriptors
// for a spare one when the leftover is larger than a header, and updates
// the tables. A free reads and checks the descriptors in turn, then reads
// the size and updates. A reinitialize rewrites the initial descriptor.
// After reset the block writes the initial descriptor before it is ready.
// One result word follows each request through an output register.
module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffba_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffba_pkg::out_word_t m_data,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_wdata
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int WW = ffba_pkg::WORD_W;
    localparam logic [WW-1:0] ALIGN_MASK = WW'(ffba_pkg::ALIGN_BYTES - 1);
    localparam logic [22:0] HDR23 = 23'(HEADER_BYTES);
    localparam logic [23:0] HDR24 = 24'(HEADER_BYTES);
    localparam logic [23:0] INIT_RESET = 24'(ffba_pkg::POOL_LIMIT - 24'(HEADER_BYTES));

    localparam logic [4:0] ST_INIT  = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_ROUND = 5'd3;
    localparam logic [4:0] ST_AORD  = 5'd4;
    localparam logic [4:0] ST_ASIZE = 5'd5;
    localparam logic [4:0] ST_ACMP  = 5'd6;
    localparam logic [4:0] ST_RMRD  = 5'd7;
    localparam logic [4:0] ST_RMWR  = 5'd8;
    localparam logic [4:0] ST_RMEND = 5'd9;
    localparam logic [4:0] ST_SPARE = 5'd10;
    localparam logic [4:0] ST_SPRD  = 5'd11;
    localparam logic [4:0] ST_SPWR  = 5'd12;
    localparam logic [4:0] ST_SPWR2 = 5'd13;
    localparam logic [4:0] ST_MKRD  = 5'd14;
    localparam logic [4:0] ST_MKWR  = 5'd15;
    localparam logic [4:0] ST_FRD   = 5'd16;
    localparam logic [4:0] ST_FCMP  = 5'd17;
    localparam logic [4:0] ST_FSZ   = 5'd18;
    localparam logic [4:0] ST_FUPD  = 5'd19;
    localparam logic [4:0] ST_DONE  = 5'd20;

    logic [22:0]   start_mem [MAX_BLOCKS];
    logic [23:0]   size_mem  [MAX_BLOCKS];
    logic [IW-1:0] order_mem [MAX_BLOCKS];

    logic          start_we, size_we, order_we;
    logic [IW-1:0] start_wa, size_wa, order_wa;
    logic [IW-1:0] start_ra, size_ra, order_ra;
    logic [22:0]   start_wd, start_q;
    logic [23:0]   size_wd, size_q;
    logic [IW-1:0] order_wd, order_q;

    logic [4:0]      state_reg, state_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next, in_use_reg, in_use_next;
    logic [22:0]     addr_reg, addr_next;
    logic [WW-1:0]   x_reg, x_next, r_reg, r_next;
    logic [IW-1:0]   pos_reg, pos_next, d_reg, d_next, cur_reg, cur_next;
    logic [IW-1:0]   sel_pos_reg, sel_pos_next, k_reg, k_next;
    logic [23:0]     sel_size_reg, sel_size_next, diff_reg, diff_next;
    logic            exact_reg, exact_next, lg_reg, lg_next;
    logic [LW-1:0]   free_len_reg, free_len_next, used_len_reg, used_len_next;
    logic [23:0]     free_sum_reg, free_sum_next, used_sum_reg, used_sum_next;
    logic [1:0]      status_reg, status_next;
    logic [22:0]     payload_reg, payload_next;
    logic [23:0]     pool_reg, pool_next, init_reg, init_next;
    logic            reinit_reg, reinit_next, m_valid_reg, m_valid_next;
    ffba_pkg::out_word_t m_data_reg, m_data_next;

    ffba_pkg::alu_in_t  alu_in;
    ffba_pkg::alu_out_t alu_out;

    ffba_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    always_ff @(posedge aclk) begin
        if (start_we) begin
            start_mem[start_wa] <= start_wd;
        end
        start_q <= start_mem[start_ra];
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_wa] <= size_wd;
        end
        size_q <= size_mem[size_ra];
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_wa] <= order_wd;
        end
        order_q <= order_mem[order_ra];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        logic          last;
        logic          take_lg;
        logic [IW-1:0] pos_eff;
        logic [23:0]   pool_c;

        state_next    = state_reg;
        valid_next    = valid_reg;
        in_use_next   = in_use_reg;
        addr_next     = addr_reg;
        x_next        = x_reg;
        r_next        = r_reg;
        pos_next      = pos_reg;
        d_next        = d_reg;
        cur_next      = cur_reg;
        sel_pos_next  = sel_pos_reg;
        k_next        = k_reg;
        sel_size_next = sel_size_reg;
        diff_next     = diff_reg;
        exact_next    = exact_reg;
        lg_next       = lg_reg;
        free_len_next = free_len_reg;
        used_len_next = used_len_reg;
        free_sum_next = free_sum_reg;
        used_sum_next = used_sum_reg;
        status_next   = status_reg;
        payload_next  = payload_reg;
        pool_next     = cfg_we ? cfg_wdata : pool_reg;
        init_next     = init_reg;
        reinit_next   = reinit_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        start_we = 1'b0;
        size_we  = 1'b0;
        order_we = 1'b0;
        start_wa = d_reg;
        size_wa  = d_reg;
        order_wa = pos_reg;
        start_wd = '0;
        size_wd  = '0;
        order_wd = '0;
        start_ra = d_reg;
        size_ra  = d_reg;
        order_ra = pos_reg;

        last    = ((LW'(pos_reg) + LW'(1)) == free_len_reg);
        take_lg = 1'b0;
        pos_eff = sel_pos_reg;
        pool_c  = (pool_reg > ffba_pkg::POOL_LIMIT) ? ffba_pkg::POOL_LIMIT : pool_reg;

        alu_in.a = '0;
        alu_in.b = '0;

        unique case (state_reg)
            ST_INIT: begin
                valid_next    = '0;
                valid_next[0] = 1'b1;
                in_use_next   = '0;
                start_we      = 1'b1;
                start_wa      = '0;
                size_we       = 1'b1;
                size_wa       = '0;
                size_wd       = init_reg;
                order_we      = 1'b1;
                order_wa      = '0;
                free_len_next = LW'(1);
                free_sum_next = init_reg;
                used_len_next = '0;
                used_sum_next = '0;
                reinit_next   = 1'b0;
                state_next    = reinit_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    status_next  = ffba_pkg::STATUS_OK;
                    payload_next = '0;
                    addr_next    = s_data.free_addr;
                    unique case (s_data.func)
                        ffba_pkg::FUNC_ALLOC: begin
                            x_next     = WW'(s_data.req_size);
                            state_next = ST_ROUND;
                        end
                        ffba_pkg::FUNC_FREE: begin
                            d_next     = '0;
                            state_next = ST_FRD;
                        end
                        ffba_pkg::FUNC_REINIT: begin
                            init_next   = (pool_c > HDR24) ? (pool_c - HDR24) : '0;
                            reinit_next = 1'b1;
                            state_next  = ST_INIT;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ROUND: begin
                alu_in.a = x_reg;
                alu_in.b = ALIGN_MASK;
                r_next   = alu_out.sum & ~ALIGN_MASK;
                pos_next = '0;
                lg_next  = 1'b0;
                if (free_len_reg == '0) begin
                    status_next = ffba_pkg::STATUS_NO_FIT;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_AORD;
                end
            end
            ST_AORD: begin
                order_ra   = pos_reg;
                state_next = ST_ASIZE;
            end
            ST_ASIZE: begin
                cur_next   = order_q;
                size_ra    = order_q;
                state_next = ST_ACMP;
            end
            ST_ACMP: begin
                alu_in.a = WW'(size_q);
                alu_in.b = r_reg;
                if (alu_out.eq) begin
                    d_next        = cur_reg;
                    sel_size_next = size_q;
                    exact_next    = 1'b1;
                    state_next    = last ? ST_RMEND : ST_RMRD;
                end else begin
                    take_lg = alu_out.gt && !lg_reg;
                    if (take_lg) begin
                        sel_pos_next  = pos_reg;
                        d_next        = cur_reg;
                        sel_size_next = size_q;
                        lg_next       = 1'b1;
                        pos_eff       = pos_reg;
                    end
                    if (last) begin
                        if (lg_reg || take_lg) begin
                            exact_next = 1'b0;
                            pos_next   = pos_eff;
                            if ((LW'(pos_eff) + LW'(1)) == free_len_reg) begin
                                state_next = ST_RMEND;
                            end else begin
                                state_next = ST_RMRD;
                            end
                        end else begin
                            status_next = ffba_pkg::STATUS_NO_FIT;
                            state_next  = ST_DONE;
                        end
                    end else begin
                        pos_next   = pos_reg + IW'(1);
                        state_next = ST_AORD;
                    end
                end
            end
            ST_RMRD: begin
                order_ra   = pos_reg + IW'(1);
                state_next = ST_RMWR;
            end
            ST_RMWR: begin
                order_we = 1'b1;
                order_wa = pos_reg;
                order_wd = order_q;
                pos_next = pos_reg + IW'(1);
                if ((LW'(pos_reg) + LW'(2)) == free_len_reg) begin
                    state_next = ST_RMEND;
                end else begin
                    state_next = ST_RMRD;
                end
            end
            ST_RMEND: begin
                free_len_next = free_len_reg - LW'(1);
                free_sum_next = free_sum_reg - sel_size_reg;
                diff_next     = sel_size_reg - r_reg[23:0];
                k_next        = '0;
                if (exact_reg) begin
                    state_next = ST_MKRD;
                end else if ((sel_size_reg - r_reg[23:0]) > HDR24) begin
                    state_next = ST_SPARE;
                end else begin
                    state_next = ST_MKRD;
                end
            end
            ST_SPARE: begin
                if (!valid_reg[k_reg]) begin
                    state_next = ST_SPRD;
                end else if (k_reg == IW'(MAX_BLOCKS - 1)) begin
                    state_next = ST_MKRD;
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_SPRD: begin
                start_ra   = d_reg;
                state_next = ST_SPWR;
            end
            ST_SPWR: begin
                start_we           = 1'b1;
                start_wa           = k_reg;
                start_wd           = start_q + HDR23 + r_reg[22:0];
                size_we            = 1'b1;
                size_wa            = k_reg;
                size_wd            = diff_reg - HDR24;
                payload_next       = start_q + HDR23;
                valid_next[k_reg]  = 1'b1;
                in_use_next[k_reg] = 1'b0;
                state_next         = ST_SPWR2;
            end
            ST_SPWR2: begin
                size_we            = 1'b1;
                size_wa            = d_reg;
                size_wd            = r_reg[23:0];
                in_use_next[d_reg] = 1'b1;
                used_len_next      = used_len_reg + LW'(1);
                used_sum_next      = used_sum_reg + r_reg[23:0];
                if (free_len_reg < LW'(MAX_BLOCKS)) begin
                    order_we      = 1'b1;
                    order_wa      = free_len_reg[IW-1:0];
                    order_wd      = k_reg;
                    free_len_next = free_len_reg + LW'(1);
                    free_sum_next = free_sum_reg + (diff_reg - HDR24);
                end
                state_next = ST_DONE;
            end
            ST_MKRD: begin
                start_ra   = d_reg;
                state_next = ST_MKWR;
            end
            ST_MKWR: begin
                payload_next       = start_q + HDR23;
                in_use_next[d_reg] = 1'b1;
                used_len_next      = used_len_reg + LW'(1);
                used_sum_next      = used_sum_reg + sel_size_reg;
                state_next         = ST_DONE;
            end
            ST_FRD: begin
                start_ra   = d_reg;
                state_next = ST_FCMP;
            end
            ST_FCMP: begin
                alu_in.a = WW'(start_q);
                alu_in.b = WW'(HDR23);
                if (valid_reg[d_reg] && in_use_reg[d_reg] &&
                    (alu_out.sum[22:0] == addr_reg)) begin
                    state_next = ST_FSZ;
                end else if (d_reg == IW'(MAX_BLOCKS - 1)) begin
                    status_next = ffba_pkg::STATUS_UNKNOWN;
                    state_next  = ST_DONE;
                end else begin
                    d_next     = d_reg + IW'(1);
                    state_next = ST_FRD;
                end
            end
            ST_FSZ: begin
                size_ra    = d_reg;
                state_next = ST_FUPD;
            end
            ST_FUPD: begin
                in_use_next[d_reg] = 1'b0;
                used_len_next      = used_len_reg - LW'(1);
                used_sum_next      = used_sum_reg - size_q;
                if (free_len_reg < LW'(MAX_BLOCKS)) begin
                    order_we      = 1'b1;
                    order_wa      = free_len_reg[IW-1:0];
                    order_wd      = d_reg;
                    free_len_next = free_len_reg + LW'(1);
                    free_sum_next = free_sum_reg + size_q;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.payload_addr = payload_reg;
                    m_data_next.free_total   = free_sum_reg;
                    m_data_next.free_blocks  = 7'(free_len_reg);
                    m_data_next.used_total   = used_sum_reg;
                    m_data_next.used_blocks  = 7'(used_len_reg);
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            valid_reg    <= '0;
            in_use_reg   <= '0;
            free_len_reg <= '0;
            used_len_reg <= '0;
            free_sum_reg <= '0;
            used_sum_reg <= '0;
            pool_reg     <= ffba_pkg::POOL_LIMIT;
            init_reg     <= INIT_RESET;
            reinit_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            in_use_reg   <= in_use_next;
            free_len_reg <= free_len_next;
            used_len_reg <= used_len_next;
            free_sum_reg <= free_sum_next;
            used_sum_reg <= used_sum_next;
            pool_reg     <= pool_next;
            init_reg     <= init_next;
            reinit_reg   <= reinit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        pos_reg      <= pos_next;
        d_reg        <= d_next;
        cur_reg      <= cur_next;
        sel_pos_reg  <= sel_pos_next;
        k_reg        <= k_next;
        sel_size_reg <= sel_size_next;
        diff_reg     <= diff_next;
        exact_reg    <= exact_next;
        lg_reg       <= lg_next;
        status_reg   <= status_next;
        payload_reg  <= payload_next;
        m_data_reg   <= m_data_next;
    end

    // The free list never holds more entries than there are descriptors.
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_len_reg <= LW'(MAX_BLOCKS))
        else $error("free list longer than the descriptor table");

    // Free and allocated blocks together never exceed the descriptor count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(free_len_reg) + 32'(used_len_reg)) <= 32'(MAX_BLOCKS))
        else $error("free and used block counts exceed the descriptor table");

    // An accepted request word closes the input until its result is produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in progress");

endmodule

>>> dv/tb_top.sv
// Testbench for the first-fit block allocator: random and directed requests,
// a scoreboard class holding a behavioral model of the descriptor table.
// Depends on ffba_pkg and first_fit_block_allocator_unit.
module tb_top;

    localparam int NBLK = 64;
    localparam int HDR = 16;

    class alloc_scoreboard;
        logic [23:0] pool_cfg;
        logic [22:0] blk_start[NBLK];
        logic [23:0] blk_size[NBLK];
        bit blk_valid[NBLK];
        bit blk_used[NBLK];
        int order[NBLK];
        int free_len;
        logic [23:0] free_sum;
        int used_len;
        logic [23:0] used_sum;
        ffba_pkg::out_word_t pending[$];
        int errors;

        function void init_pool();
            logic [23:0] p;
            p = (pool_cfg > ffba_pkg::POOL_LIMIT) ? ffba_pkg::POOL_LIMIT : pool_cfg;
            for (int i = 0; i < NBLK; i++) begin
                blk_start[i] = '0;
                blk_size[i] = '0;
                blk_valid[i] = 0;
                blk_used[i] = 0;
                order[i] = 0;
            end
            blk_valid[0] = 1;
            blk_size[0] = (p > 24'(HDR)) ? p - 24'(HDR) : '0;
            free_len = 1;
            free_sum = blk_size[0];
            used_len = 0;
            used_sum = '0;
        endfunction

        function void take(int pos);
            int d;
            d = order[pos];
            for (int i = pos; i + 1 < free_len; i++) order[i] = order[i + 1];
            free_len--;
            free_sum -= blk_size[d];
            blk_used[d] = 1;
        endfunction

        function void push_free(int d);
            if (free_len < NBLK) begin
                order[free_len] = d;
                free_len++;
                free_sum += blk_size[d];
            end
        endfunction

        function int allocate(logic [23:0] req);
            longint r;
            int d, spare;
            longint diff;
            r = (longint'(req) + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES
                * ffba_pkg::ALIGN_BYTES;
            for (int p = 0; p < free_len; p++) begin
                d = order[p];
                if (longint'(blk_size[d]) == r) begin
                    take(p);
                    used_len++;
                    used_sum += blk_size[d];
                    return d;
                end
            end
            for (int p = 0; p < free_len; p++) begin
                d = order[p];
                if (longint'(blk_size[d]) > r) begin
                    diff = longint'(blk_size[d]) - r;
                    spare = NBLK;
                    take(p);
                    if (diff > HDR) begin
                        for (int k = 0; k < NBLK; k++) begin
                            if (!blk_valid[k]) begin
                                spare = k;
                                break;
                            end
                        end
                    end
                    if (spare < NBLK) begin
                        blk_valid[spare] = 1;
                        blk_used[spare] = 0;
                        blk_start[spare] = blk_start[d] + 23'(HDR) + r[22:0];
                        blk_size[spare] = 24'(diff - HDR);
                        blk_size[d] = r[23:0];
                    end
                    used_len++;
                    used_sum += blk_size[d];
                    if (spare < NBLK) push_free(spare);
                    return d;
                end
            end
            return NBLK;
        endfunction

        function void note_request(ffba_pkg::in_word_t w);
            ffba_pkg::out_word_t o;
            int d;
            o = '0;
            if (w.func == ffba_pkg::FUNC_ALLOC) begin
                d = allocate(w.req_size);
                if (d < NBLK) o.payload_addr = blk_start[d] + 23'(HDR);
                else o.status = ffba_pkg::STATUS_NO_FIT;
            end else if (w.func == ffba_pkg::FUNC_FREE) begin
                o.status = ffba_pkg::STATUS_UNKNOWN;
                for (d = 0; d < NBLK; d++) begin
                    if (blk_valid[d] && blk_used[d] &&
                            blk_start[d] + 23'(HDR) == w.free_addr) begin
                        blk_used[d] = 0;
                        used_len--;
                        used_sum -= blk_size[d];
                        push_free(d);
                        o.status = ffba_pkg::STATUS_OK;
                        break;
                    end
                end
            end else if (w.func == ffba_pkg::FUNC_REINIT) begin
                init_pool();
            end
            o.free_total = free_sum;
            o.free_blocks = free_len[6:0];
            o.used_total = used_sum;
            o.used_blocks = used_len[6:0];
            pending.push_back(o);
        endfunction

        function void check_result(ffba_pkg::out_word_t got);
            ffba_pkg::out_word_t exp_w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected st=%0d pa=%h ft=%h fb=%0d ut=%h ub=%0d,",
                        exp_w.status, exp_w.payload_addr, exp_w.free_total,
                        exp_w.free_blocks, exp_w.used_total, exp_w.used_blocks,
                        " got st=%0d pa=%h ft=%h fb=%0d ut=%h ub=%0d",
                        got.status, got.payload_addr, got.free_total,
                        got.free_blocks, got.used_total, got.used_blocks);
            end
        endfunction
    endclass

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready, cfg_we;
    ffba_pkg::in_word_t s_data;
    ffba_pkg::out_word_t m_data;
    logic [23:0] cfg_wdata;
    alloc_scoreboard sb;
    int hold_cycles;
    bit rx_random;
    longint cycle_count;
    logic [22:0] live_addrs[$];

    first_fit_block_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 64'd6000000) begin
                $display("FAIL first_fit_block_allocator_unit");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
            if (m_data.status == ffba_pkg::STATUS_OK && m_data.payload_addr != 0)
                live_addrs.push_back(m_data.payload_addr);
        end
    end

    initial begin
        m_ready = 0;
        hold_cycles = 0;
        rx_random = 1;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 0;
            end else if (!rx_random) begin
                m_ready <= 1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0) ||
                           ($urandom_range(0, 40) == 0 ? 0 : 1);
                if ($urandom_range(0, 200) == 0) hold_cycles = $urandom_range(20, 300);
                else if ($urandom_range(0, 4) == 0) hold_cycles = $urandom_range(1, 3);
            end
        end
    end

    task automatic send_word(input ffba_pkg::in_word_t w);
        s_data = w;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(w);
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 2) == 0) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic write_pool(input logic [23:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1;
        @(negedge aclk);
        cfg_we <= 0;
        sb.pool_cfg = v;
        live_addrs.delete();
    endtask

    function automatic ffba_pkg::in_word_t make_word(logic [1:0] f, logic [23:0] sz,
                                                     logic [22:0] a);
        ffba_pkg::in_word_t w;
        w.func = f;
        w.req_size = sz;
        w.free_addr = a;
        return w;
    endfunction

    task automatic random_item(input logic [23:0] pool);
        int k, idx;
        logic [23:0] sz;
        logic [22:0] a;
        k = $urandom_range(0, 99);
        if (k < 50) begin
            if ($urandom_range(0, 9) == 0) sz = 24'($urandom_range(0, 24'hFFFFFF));
            else sz = 24'($urandom_range(0, (pool >> 4) + 64));
            send_word(make_word(ffba_pkg::FUNC_ALLOC, sz,
                                23'($urandom_range(0, 23'h7FFFFF))));
        end else if (k < 88) begin
            if (live_addrs.size() != 0 && $urandom_range(0, 5) != 0) begin
                idx = $urandom_range(0, live_addrs.size() - 1);
                a = live_addrs[idx];
                live_addrs.delete(idx);
            end else begin
                a = 23'($urandom_range(0, 23'h7FFFFF));
            end
            send_word(make_word(ffba_pkg::FUNC_FREE, 24'($urandom_range(0, 24'hFFFFFF)), a));
        end else if (k < 97) begin
            send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'($urandom_range(0, 24'hFFFFFF)),
                                23'($urandom_range(0, 23'h7FFFFF))));
        end else if (k < 99) begin
            send_word(make_word(ffba_pkg::FUNC_REINIT, 24'($urandom_range(0, 24'hFFFFFF)),
                                23'($urandom_range(0, 23'h7FFFFF))));
            live_addrs.delete();
        end else begin
            send_word(make_word(2'd3, 24'($urandom_range(0, 24'hFFFFFF)),
                                23'($urandom_range(0, 23'h7FFFFF))));
        end
        sender_gap();
    endtask

    initial begin
        logic [23:0] pools[6];
        sb = new();
        sb.errors = 0;
        sb.pool_cfg = 24'h800000;
        sb.init_pool();
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1;

        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd0, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd1, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd32, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_FREE, 24'd0, 23'd16));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd32, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_FREE, 24'd0, 23'd5));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'hFFFFFF, 23'h7FFFFF));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'h800000, 23'd0));
        send_word(make_word(2'd3, 24'hFFFFFF, 23'h7FFFFF));
        send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'h7FFFE0, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_FREE, 24'd0, 23'h7FFFFF));
        send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
        // A leftover larger than one header splits off a spare block.
        write_pool(24'd112);
        send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd64, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_FREE, 24'd0, 23'd16));
        write_pool(24'd8);
        send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
        send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd0, 23'd0));
        write_pool(24'hFFFFFF);
        send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
        // Exhaust the descriptors with small allocations.
        write_pool(24'd4096);
        send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
        repeat (70) send_word(make_word(ffba_pkg::FUNC_ALLOC, 24'd1, 23'd0));
        drain();

        pools = '{24'd64, 24'd4096, 24'd65536, 24'h800000, 24'hFFFFFF, 24'd2000};
        for (int ph = 0; ph < 6; ph++) begin
            write_pool(pools[ph]);
            send_word(make_word(ffba_pkg::FUNC_REINIT, 24'd0, 23'd0));
            if (ph == 2) begin
                hold_cycles = 3000;
                repeat (30) random_item(pools[ph]);
                drain();
            end
            if (ph == 4) begin
                rx_random = 0;
                repeat (60) random_item(pools[ph]);
                rx_random = 1;
            end
            repeat (210) random_item(pools[ph]);
        end

        drain();
        if (sb.errors == 0) begin
            $display("PASS first_fit_block_allocator_unit");
        end else begin
            $display("FAIL first_fit_block_allocator_unit");
        end
        $finish;
    end
endmodule
